// File: hw/rtl/xpet_pkg.sv
// package for the xpath expression tokenizer
// token kinds, scan modes, error codes, character and keyword helpers; no dependencies
package xpet_pkg;

    localparam int MaxTextLenDefault = 65536;
    localparam int MaxNameLenDefault = 24;
    localparam int OffsetWidth       = 16;
    localparam int KindWidth         = 6;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_STR  = 6'b000010,
        MODE_INT  = 6'b000100,
        MODE_FRAC = 6'b001000,
        MODE_NAME = 6'b010000,
        MODE_OP   = 6'b100000
    } scan_mode_t;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [1:0] ERR_BANG     = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_ERR      = 6'd1;
    localparam logic [5:0] K_STR      = 6'd2;
    localparam logic [5:0] K_NUM      = 6'd3;
    localparam logic [5:0] K_IDENT    = 6'd4;
    localparam logic [5:0] K_FUNC     = 6'd5;
    localparam logic [5:0] K_SLASH    = 6'd27;
    localparam logic [5:0] K_DSLASH   = 6'd28;
    localparam logic [5:0] K_DOT      = 6'd29;
    localparam logic [5:0] K_DDOT     = 6'd30;
    localparam logic [5:0] K_AT       = 6'd31;
    localparam logic [5:0] K_STAR     = 6'd32;
    localparam logic [5:0] K_LPAREN   = 6'd33;
    localparam logic [5:0] K_RPAREN   = 6'd34;
    localparam logic [5:0] K_LBRACK   = 6'd35;
    localparam logic [5:0] K_RBRACK   = 6'd36;
    localparam logic [5:0] K_PIPE     = 6'd37;
    localparam logic [5:0] K_COLON    = 6'd38;
    localparam logic [5:0] K_DCOLON   = 6'd39;
    localparam logic [5:0] K_EQ       = 6'd40;
    localparam logic [5:0] K_NE       = 6'd41;
    localparam logic [5:0] K_LT       = 6'd42;
    localparam logic [5:0] K_LE       = 6'd43;
    localparam logic [5:0] K_GT       = 6'd44;
    localparam logic [5:0] K_GE       = 6'd45;
    localparam logic [5:0] K_PLUS     = 6'd46;
    localparam logic [5:0] K_MINUS    = 6'd47;
    localparam logic [5:0] K_COMMA    = 6'd48;

    // one result of a step
    typedef struct packed {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [15:0] start;
        logic [15:0] len;
    } token_t;

    // results of one step, at most two
    typedef struct packed {
        logic   [1:0] count;
        token_t       tok0;
        token_t       tok1;
    } step_out_t;

    localparam int WordCount = 48;
    localparam int WordChars = 22;

    typedef struct packed {
        logic [WordChars*8-1:0] text;  // first char in low byte
        logic [4:0]             len;
        logic [5:0]             kind;
    } word_t;

    function automatic word_t mkw(input string s, input logic [5:0] k);
        word_t w;
        w = '0;
        for (int i = 0; i < WordChars; i++) begin
            if (i < s.len()) begin
                w.text[i*8 +: 8] = s[i];
            end
        end
        w.len  = 5'(s.len());
        w.kind = k;
        return w;
    endfunction

    function automatic word_t word_at(input int i);
        word_t w;
        unique case (i)
            0:  w = mkw("and", 6'd6);
            1:  w = mkw("or", 6'd7);
            2:  w = mkw("div", 6'd8);
            3:  w = mkw("mod", 6'd9);
            4:  w = mkw("ancestor", 6'd10);
            5:  w = mkw("ancestor-or-self", 6'd11);
            6:  w = mkw("attribute", 6'd12);
            7:  w = mkw("child", 6'd13);
            8:  w = mkw("descendant", 6'd14);
            9:  w = mkw("descendant-or-self", 6'd15);
            10: w = mkw("following", 6'd16);
            11: w = mkw("following-sibling", 6'd17);
            12: w = mkw("namespace", 6'd18);
            13: w = mkw("parent", 6'd19);
            14: w = mkw("preceding", 6'd20);
            15: w = mkw("preceding-sibling", 6'd21);
            16: w = mkw("self", 6'd22);
            17: w = mkw("comment", 6'd23);
            18: w = mkw("text", 6'd24);
            19: w = mkw("processing-instruction", 6'd25);
            20: w = mkw("node", 6'd26);
            21: w = mkw("last", K_FUNC);
            22: w = mkw("position", K_FUNC);
            23: w = mkw("count", K_FUNC);
            24: w = mkw("id", K_FUNC);
            25: w = mkw("local-name", K_FUNC);
            26: w = mkw("namespace-uri", K_FUNC);
            27: w = mkw("name", K_FUNC);
            28: w = mkw("string", K_FUNC);
            29: w = mkw("concat", K_FUNC);
            30: w = mkw("starts-with", K_FUNC);
            31: w = mkw("contains", K_FUNC);
            32: w = mkw("substring-before", K_FUNC);
            33: w = mkw("substring-after", K_FUNC);
            34: w = mkw("substring", K_FUNC);
            35: w = mkw("string-length", K_FUNC);
            36: w = mkw("normalize-space", K_FUNC);
            37: w = mkw("translate", K_FUNC);
            38: w = mkw("boolean", K_FUNC);
            39: w = mkw("not", K_FUNC);
            40: w = mkw("true", K_FUNC);
            41: w = mkw("false", K_FUNC);
            42: w = mkw("lang", K_FUNC);
            43: w = mkw("number", K_FUNC);
            44: w = mkw("sum", K_FUNC);
            45: w = mkw("floor", K_FUNC);
            46: w = mkw("ceiling", K_FUNC);
            default: w = mkw("round", K_FUNC);
        endcase
        return w;
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0a || b == 8'h0d;
    endfunction

endpackage

// File: hw/rtl/xpet_classify.sv
// name classifier: parallel compare of the name buffer against the word list
// depends on xpet_pkg
module xpet_classify import xpet_pkg::*; #(
    parameter int MAX_NAME_LEN = MaxNameLenDefault
) (
    input  logic [MAX_NAME_LEN*8-1:0]         name_buf,
    input  logic [$clog2(MAX_NAME_LEN+1)-1:0] name_len,
    input  logic                              name_ovf,
    input  logic                              paren_next,
    output logic [5:0]                        kind
);
    logic [WordCount-1:0] hit;
    logic [5:0]           word_kind;

    always_comb begin
        for (int i = 0; i < WordCount; i++) begin
            hit[i] = 1'b1;
            if (32'(name_len) != 32'(word_at(i).len)) begin
                hit[i] = 1'b0;
            end
            for (int c = 0; c < WordChars; c++) begin
                if (c < word_at(i).len && c < MAX_NAME_LEN) begin
                    if (name_buf[c*8 +: 8] != word_at(i).text[c*8 +: 8]) begin
                        hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        word_kind = '0;
        for (int i = 0; i < WordCount; i++) begin
            word_kind = word_kind | (hit[i] ? word_at(i).kind : 6'd0);
        end
        if (!name_ovf && hit != '0) begin
            kind = word_kind;
        end else begin
            kind = paren_next ? K_FUNC : K_IDENT;
        end
    end
endmodule

// File: hw/rtl/xpet_scan.sv
// scanner state and per-byte token logic, one byte per cycle while step_en is high
// depends on xpet_pkg and xpet_classify
module xpet_scan import xpet_pkg::*; #(
    parameter int MAX_TEXT_LEN = MaxTextLenDefault,
    parameter int MAX_NAME_LEN = MaxNameLenDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic       eoi,
    input  logic [7:0] b,
    output step_out_t  res
);
    localparam int NLW = $clog2(MAX_NAME_LEN + 1);
    localparam logic [15:0] PosLimit =
        (MAX_TEXT_LEN - 1 > 65535) ? 16'hffff : 16'(MAX_TEXT_LEN - 1);

    scan_mode_t mode_reg, mode_next;
    logic [15:0] off_reg, start_reg, start_next;
    logic quote_reg, quote_next, esc_reg, esc_next;
    logic [7:0] op_reg, op_next;
    logic [MAX_NAME_LEN*8-1:0] name_reg;
    logic [NLW-1:0] nlen_reg, nlen_next;
    logic novf_reg, novf_next;
    logic wr_en;
    logic [NLW-1:0] wr_idx;
    logic [5:0] class_kind;
    logic consumed;
    token_t t0, t1, single_op;
    logic [1:0] n;
    logic [5:0] pair_kind, start_kind;

    xpet_classify #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_class (
        .name_buf  (name_reg),
        .name_len  (nlen_reg),
        .name_ovf  (novf_reg),
        .paren_next(!eoi && b == "("),
        .kind      (class_kind)
    );

    function automatic token_t tk(input logic [5:0] k, input logic [1:0] e,
                                  input logic [15:0] s, input logic [16:0] en);
        token_t t;
        logic [16:0] l;
        l = (en >= {1'b0, s}) ? en - {1'b0, s} : 17'd0;
        t.kind  = k;
        t.err   = e;
        t.start = s;
        t.len   = l[16] ? 16'hffff : l[15:0];
        return t;
    endfunction

    always_comb begin
        unique case (op_reg)
            "/":     single_op = tk(K_SLASH, ERR_NONE, start_reg, {1'b0, start_reg} + 17'd1);
            ".":     single_op = tk(K_DOT, ERR_NONE, start_reg, {1'b0, start_reg} + 17'd1);
            ":":     single_op = tk(K_COLON, ERR_NONE, start_reg, {1'b0, start_reg} + 17'd1);
            "<":     single_op = tk(K_LT, ERR_NONE, start_reg, {1'b0, start_reg} + 17'd1);
            ">":     single_op = tk(K_GT, ERR_NONE, start_reg, {1'b0, start_reg} + 17'd1);
            default: single_op = tk(K_ERR, ERR_BANG, start_reg, {1'b0, start_reg} + 17'd1);
        endcase
        pair_kind = '0;
        if (op_reg == "/" && b == "/") pair_kind = K_DSLASH;
        else if (op_reg == "." && b == ".") pair_kind = K_DDOT;
        else if (op_reg == ":" && b == ":") pair_kind = K_DCOLON;
        else if (op_reg == "!" && b == "=") pair_kind = K_NE;
        else if (op_reg == "<" && b == "=") pair_kind = K_LE;
        else if (op_reg == ">" && b == "=") pair_kind = K_GE;
        unique case (b)
            "@":     start_kind = K_AT;
            "*":     start_kind = K_STAR;
            "(":     start_kind = K_LPAREN;
            ")":     start_kind = K_RPAREN;
            "[":     start_kind = K_LBRACK;
            "]":     start_kind = K_RBRACK;
            "|":     start_kind = K_PIPE;
            "=":     start_kind = K_EQ;
            "+":     start_kind = K_PLUS;
            "-":     start_kind = K_MINUS;
            ",":     start_kind = K_COMMA;
            default: start_kind = K_ERR;
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        op_next    = op_reg;
        nlen_next  = nlen_reg;
        novf_next  = novf_reg;
        wr_en      = 1'b0;
        wr_idx     = nlen_reg;
        consumed   = 1'b0;
        n          = 2'd0;
        t0         = '0;
        t1         = '0;
        if (eoi) begin
            unique case (mode_reg)
                MODE_STR: begin
                    t0 = tk(K_ERR, ERR_UNCLOSED, start_reg, {1'b0, off_reg});
                    n = 2'd1;
                end
                MODE_INT, MODE_FRAC: begin
                    t0 = tk(K_NUM, ERR_NONE, start_reg, {1'b0, off_reg});
                    n = 2'd1;
                end
                MODE_NAME: begin
                    t0 = tk(class_kind, ERR_NONE, start_reg, {1'b0, off_reg});
                    n = 2'd1;
                end
                MODE_OP: begin
                    t0 = single_op;
                    n = 2'd1;
                end
                default: n = 2'd0;
            endcase
            if (n == 2'd0) begin
                t0 = tk(K_EOF, ERR_NONE, off_reg, {1'b0, off_reg});
            end else begin
                t1 = tk(K_EOF, ERR_NONE, off_reg, {1'b0, off_reg});
            end
            n = n + 2'd1;
            mode_next  = MODE_IDLE;
            start_next = '0;
            quote_next = 1'b0;
            esc_next   = 1'b0;
            op_next    = '0;
            nlen_next  = '0;
            novf_next  = 1'b0;
        end else begin
            unique case (mode_reg)
                MODE_STR: begin
                    consumed = 1'b1;
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (b == 8'h5c) begin
                        esc_next = 1'b1;
                    end else if (b == (quote_reg ? 8'h27 : 8'h22)) begin
                        t0 = tk(K_STR, ERR_NONE, start_reg, {1'b0, off_reg} + 17'd1);
                        n = 2'd1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_INT: begin
                    if (is_dec_digit(b)) begin
                        consumed = 1'b1;
                    end else if (b == ".") begin
                        consumed = 1'b1;
                        mode_next = MODE_FRAC;
                    end else begin
                        t0 = tk(K_NUM, ERR_NONE, start_reg, {1'b0, off_reg});
                        n = 2'd1;
                    end
                end
                MODE_FRAC: begin
                    if (is_dec_digit(b)) begin
                        consumed = 1'b1;
                    end else begin
                        t0 = tk(K_NUM, ERR_NONE, start_reg, {1'b0, off_reg});
                        n = 2'd1;
                    end
                end
                MODE_NAME: begin
                    if (is_alpha(b) || is_dec_digit(b) || b == "_" || b == "-") begin
                        consumed = 1'b1;
                        if (32'(nlen_reg) < MAX_NAME_LEN) begin
                            wr_en = 1'b1;
                            nlen_next = nlen_reg + NLW'(1);
                        end else begin
                            novf_next = 1'b1;
                        end
                    end else begin
                        t0 = tk(class_kind, ERR_NONE, start_reg, {1'b0, off_reg});
                        n = 2'd1;
                    end
                end
                MODE_OP: begin
                    if (op_reg == "." && is_dec_digit(b)) begin
                        consumed = 1'b1;
                        mode_next = MODE_FRAC;
                    end else if (pair_kind != 6'd0) begin
                        consumed = 1'b1;
                        mode_next = MODE_IDLE;
                        t0 = tk(pair_kind, ERR_NONE, start_reg, {1'b0, off_reg} + 17'd1);
                        n = 2'd1;
                    end else begin
                        t0 = single_op;
                        n = 2'd1;
                    end
                end
                default: consumed = 1'b0;
            endcase
            if (!consumed) begin
                mode_next  = MODE_IDLE;
                start_next = off_reg;
                if (is_space(b)) begin
                    mode_next = MODE_IDLE;
                end else if (b == 8'h22 || b == 8'h27) begin
                    mode_next  = MODE_STR;
                    quote_next = (b == 8'h27);
                    esc_next   = 1'b0;
                end else if (is_dec_digit(b)) begin
                    mode_next = MODE_INT;
                end else if (is_alpha(b) || b == "_") begin
                    mode_next = MODE_NAME;
                    wr_en     = 1'b1;
                    wr_idx    = '0;
                    nlen_next = NLW'(1);
                    novf_next = 1'b0;
                end else if (b == "/" || b == "." || b == ":" || b == "!" ||
                             b == "<" || b == ">") begin
                    mode_next = MODE_OP;
                    op_next   = b;
                end else begin
                    if (n == 2'd0) begin
                        t0 = tk(start_kind, (start_kind == K_ERR) ? ERR_UNKNOWN : ERR_NONE,
                                off_reg, {1'b0, off_reg} + 17'd1);
                    end else begin
                        t1 = tk(start_kind, (start_kind == K_ERR) ? ERR_UNKNOWN : ERR_NONE,
                                off_reg, {1'b0, off_reg} + 17'd1);
                    end
                    n = n + 2'd1;
                end
            end
        end
        res.count = n;
        res.tok0  = t0;
        res.tok1  = t1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            off_reg   <= '0;
            start_reg <= '0;
            quote_reg <= 1'b0;
            esc_reg   <= 1'b0;
            op_reg    <= '0;
            nlen_reg  <= '0;
            novf_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            op_reg    <= op_next;
            nlen_reg  <= nlen_next;
            novf_reg  <= novf_next;
            if (eoi) begin
                off_reg <= '0;
            end else if (off_reg < PosLimit) begin
                off_reg <= off_reg + 16'd1;
            end
        end
    end

    // name store, no reset
    always_ff @(posedge aclk) begin
        if (step_en && !eoi && wr_en) begin
            for (int i = 0; i < MAX_NAME_LEN; i++) begin
                if (32'(wr_idx) == i) begin
                    name_reg[i*8 +: 8] <= b;
                end
            end
        end
    end
endmodule

// File: hw/rtl/xpath_expression_tokenizer.sv
// Tokenizer for XPath 1.0 expressions. One byte is taken per cycle while s_tready is high;
// an end-of-input transaction flushes the pending token and gives eof. Each input
// transaction gives zero, one or two tokens. An accepted byte is held in the input register
// while it is scanned, and its tokens enter a four-entry output buffer at the next edge,
// from which the first token can be taken. Input is taken while the buffer holds at most
// two tokens after this cycle's scan, which leaves room for the worst case of the next
// byte. Sustained rate is one byte per cycle while each byte gives at most one token and
// the sink keeps up; a byte that gives two tokens can hold the input back. Names are
// classified at token end by parallel compare.
// depends on xpet_pkg, xpet_scan, xpet_classify
module xpath_expression_tokenizer import xpet_pkg::*; #(
    parameter int MAX_TEXT_LEN = MaxTextLenDefault,
    parameter int MAX_NAME_LEN = MaxNameLenDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // token_kind, error_code, start_offset, raw_length
    output logic        m_tlast    // last_of_run
);
    typedef struct packed {
        token_t tok;
        logic   last;
    } ent_t;

    step_out_t res;
    ent_t q_reg [4];
    ent_t q_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] fill, base;
    logic acc, pop;
    logic in_v_reg, in_eoi_reg;
    logic [7:0] in_b_reg;
    logic step;

    // input register feeding the scanner
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else begin
            in_v_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            in_b_reg   <= s_tdata;
            in_eoi_reg <= s_tuser;
        end
    end

    assign step = in_v_reg;

    xpet_scan #(.MAX_TEXT_LEN(MAX_TEXT_LEN), .MAX_NAME_LEN(MAX_NAME_LEN)) u_scan (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(step),
        .eoi    (in_eoi_reg),
        .b      (in_b_reg),
        .res    (res)
    );

    assign pop  = m_tvalid && m_tready;
    assign fill = cnt_reg + (step ? {1'b0, res.count} : 3'd0);
    // room for two more results from the transaction taken now
    assign s_tready = aresetn && (fill <= 3'd2);
    assign acc = s_tvalid && s_tready;

    // output buffer, stalls scanner by gating acceptance
    always_comb begin
        cnt_next = fill - {2'b00, pop};
        base     = cnt_reg - {2'b00, pop};
        q_next   = q_reg;
        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                q_next[i] = q_reg[i+1];
            end
        end
        if (step && res.count != 2'd0) begin
            q_next[base[1:0]] = '{tok: res.tok0, last: (res.count == 2'd1)};
            if (res.count == 2'd2) begin
                q_next[base[1:0] + 2'd1] = '{tok: res.tok1, last: 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign m_tvalid = cnt_reg != 3'd0;
    assign m_tdata  = {q_reg[0].tok.len, q_reg[0].tok.start, q_reg[0].tok.err,
                       q_reg[0].tok.kind};
    assign m_tlast  = q_reg[0].last;
endmodule
